// File: hdl/dtss_pkg.sv
// Shared constants, types and command/status groups for the dead tuple set store.
package dtss_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int POOL_BYTES    = 65536;
   localparam int MAX_OFFSET    = 2048;

   localparam int TAW  = $clog2(TABLE_ENTRIES);
   localparam int PAW  = $clog2(POOL_BYTES);
   localparam int PFW  = $clog2(POOL_BYTES + 1);
   localparam int RBAW = $clog2(MAX_OFFSET);
   localparam int FSW  = ((PFW > 13) ? PFW : 13) + 1;

   localparam bit TABLE_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam int MOD_STEPS  = TABLE_POW2 ? 0 : 33 - TAW;

   localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
   localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TABLE_FULL = 2'd1;
   localparam logic [1:0] ST_POOL_FULL  = 2'd2;
   localparam logic [1:0] ST_RUN_LONG   = 2'd3;

   // pool port operations
   localparam logic [3:0] P_NONE    = 4'd0;
   localparam logic [3:0] P_WR_LO   = 4'd1;
   localparam logic [3:0] P_WR_HI   = 4'd2;
   localparam logic [3:0] P_WR_ZERO = 4'd3;
   localparam logic [3:0] P_WR_BIT  = 4'd4;
   localparam logic [3:0] P_RD_LO   = 4'd5;
   localparam logic [3:0] P_RD_HI   = 4'd6;
   localparam logic [3:0] P_RD_BIT  = 4'd7;
   localparam logic [3:0] P_RD_LOOK = 4'd8;

   typedef struct packed {
      logic            valid;
      logic [31:0]     blk;
      logic            bitmap;
      logic [11:0]     len;
      logic [PAW-1:0]  start;
   } entry_type;

   typedef struct packed {
      logic        load;
      logic        add;
      logic        run_reset;
      logic        hash1;
      logic        hash2;
      logic        hash3;
      logic        mod_step;
      logic        probe_init;
      logic        probe_next;
      logic        tbl_rd;
      logic        tbl_clr;
      logic        tbl_wr_entry;
      logic        cap_entry;
      logic        sizing;
      logic        i_clr;
      logic        i_inc;
      logic        rb_rd;
      logic [3:0]  pool_op;
      logic        cap_lo;
      logic        respond;
      logic        found;
      logic        status_force;
      logic [1:0]  status_code;
   } cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic off_ok;
      logic add_drop;
      logic last;
      logic mod_done;
      logic probe_hit;
      logic entry_valid;
      logic probe_last;
      logic kind_bitmap;
      logic bm_out;
      logic bit_set;
      logic lo_match;
      logic fits;
      logic as_array;
      logic i_eq_n;
      logic i_eq_bytes;
      logic i_eq_len;
      logic clear_last;
   } stat_type;

endpackage

// File: hdl/dtss_ram.sv
// Generic simple dual-port RAM with registered read.
module dtss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dtss_dp.sv
// Datapath: request latch, run buffer, hash, block table, pool and result registers.
module dtss_dp import dtss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_command,
   input  logic [31:0] req_block_number,
   input  logic [11:0] req_offset,
   input  logic        req_last_of_run,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [1:0]  rsp_status
);

   logic            cmd_ff;
   logic [31:0]     key_ff;
   logic [11:0]     off_ff;
   logic            last_ff;
   logic [11:0]     run_count_ff, run_count_in;
   logic [11:0]     run_highest_ff, run_highest_in;
   logic [1:0]      st_ff;
   logic [31:0]     m1_ff, m2_ff, rem_ff;
   logic [5:0]      mod_left_ff;
   logic [TAW-1:0]  idx_ff, idx_in;
   logic [TAW-1:0]  pcnt_ff;
   logic [PAW-1:0]  base_ff;
   logic [11:0]     len_ff;
   logic            kind_ff;
   logic            as_arr_ff;
   logic [12:0]     bytes_ff;
   logic            fits_ff;
   logic [PFW-1:0]  pool_fill_ff, pool_fill_in;
   logic [12:0]     i_ff;
   logic [7:0]      lo_ff;
   logic            rsp_valid_ff, rsp_found_ff;
   logic [1:0]      rsp_status_ff;

   logic            off_ok, run_full;
   logic [31:0]     h0, h1x, h3, mul1, mul2;
   logic [63:0]     dv;
   logic            as_arr_c;
   logic [12:0]     bytes_c;
   logic            fits_c;
   logic [11:0]     boff, look;
   logic [PAW-1:0]  pool_addr;
   logic [7:0]      pool_wdata, pool_q;
   logic            pool_we, pool_re;
   logic [11:0]     rb_q;
   entry_type       tbl_q, tbl_wdata;
   logic            tbl_we;
   logic [12:0]     two_i;

   assign off_ok   = (off_ff != 12'd0) && (off_ff <= 12'(MAX_OFFSET));
   assign run_full = run_count_ff == 12'(MAX_OFFSET);

   // hash rounds, one multiply per cycle
   assign h0   = key_ff ^ (key_ff >> 16);
   assign mul1 = h0 * MIX_C1;
   assign h1x  = m1_ff ^ (m1_ff >> 13);
   assign mul2 = h1x * MIX_C2;
   assign h3   = m2_ff ^ (m2_ff >> 16);
   assign dv   = 64'(TABLE_ENTRIES) << (mod_left_ff - 6'd1);

   assign idx_in = (idx_ff == TAW'(TABLE_ENTRIES - 1)) ? '0 : idx_ff + TAW'(1);

   assign as_arr_c = {run_count_ff, 1'b0} <= (13'(run_highest_ff >> 3) + 13'd1);
   assign bytes_c  = as_arr_c ? {run_count_ff, 1'b1}
                              : 13'((run_highest_ff - 12'd1) >> 3) + 13'd1;
   assign fits_c   = (FSW'(pool_fill_ff) + FSW'(bytes_c)) <= FSW'(POOL_BYTES);

   assign run_count_in   = run_count_ff + 12'd1;
   assign run_highest_in = (off_ff > run_highest_ff) ? off_ff : run_highest_ff;
   assign pool_fill_in   = pool_fill_ff + PFW'(bytes_ff);

   assign boff  = rb_q - 12'd1;
   assign look  = off_ff - 12'd1;
   assign two_i = {i_ff[11:0], 1'b0};

   always_comb begin
      pool_we    = 1'b0;
      pool_re    = 1'b0;
      pool_addr  = base_ff;
      pool_wdata = 8'd0;
      case (cmd.pool_op)
         P_WR_LO: begin
            pool_we    = 1'b1;
            pool_addr  = base_ff + PAW'(two_i);
            pool_wdata = rb_q[7:0];
         end
         P_WR_HI: begin
            pool_we    = 1'b1;
            pool_addr  = base_ff + PAW'(two_i) + PAW'(1);
            pool_wdata = {4'd0, rb_q[11:8]};
         end
         P_WR_ZERO: begin
            pool_we   = 1'b1;
            pool_addr = base_ff + PAW'(i_ff);
         end
         P_WR_BIT: begin
            pool_we    = 1'b1;
            pool_addr  = base_ff + PAW'(boff >> 3);
            pool_wdata = pool_q | (8'd1 << boff[2:0]);
         end
         P_RD_LO: begin
            pool_re   = 1'b1;
            pool_addr = base_ff + PAW'(two_i);
         end
         P_RD_HI: begin
            pool_re   = 1'b1;
            pool_addr = base_ff + PAW'(two_i) + PAW'(1);
         end
         P_RD_BIT: begin
            pool_re   = 1'b1;
            pool_addr = base_ff + PAW'(boff >> 3);
         end
         P_RD_LOOK: begin
            pool_re   = 1'b1;
            pool_addr = base_ff + PAW'(look >> 3);
         end
         default: begin
            pool_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      tbl_we    = cmd.tbl_clr | cmd.tbl_wr_entry;
      tbl_wdata = '0;
      if (cmd.tbl_wr_entry) begin
         tbl_wdata.valid  = 1'b1;
         tbl_wdata.blk    = key_ff;
         tbl_wdata.bitmap = !as_arr_ff;
         tbl_wdata.len    = as_arr_ff ? run_count_ff : {bytes_ff[8:0], 3'b000};
         tbl_wdata.start  = base_ff;
      end
   end

   dtss_ram #(.WIDTH(12), .DEPTH(MAX_OFFSET)) u_run_buf (
      .clock   (clock),
      .wr_en   (cmd.add && off_ok && !run_full),
      .wr_addr (run_count_ff[RBAW-1:0]),
      .wr_data (off_ff),
      .rd_en   (cmd.rb_rd),
      .rd_addr (i_ff[RBAW-1:0]),
      .rd_data (rb_q)
   );

   dtss_ram #(.WIDTH($bits(entry_type)), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (idx_ff),
      .wr_data (tbl_wdata),
      .rd_en   (cmd.tbl_rd),
      .rd_addr (idx_ff),
      .rd_data (tbl_q)
   );

   dtss_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (
      .clock   (clock),
      .wr_en   (pool_we),
      .wr_addr (pool_addr),
      .wr_data (pool_wdata),
      .rd_en   (pool_re),
      .rd_addr (pool_addr),
      .rd_data (pool_q)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff   <= 12'd0;
         run_highest_ff <= 12'd1;
         pool_fill_ff   <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.run_reset) begin
            run_count_ff   <= 12'd0;
            run_highest_ff <= 12'd1;
         end else if (cmd.add && off_ok && !run_full) begin
            run_count_ff   <= run_count_in;
            run_highest_ff <= run_highest_in;
         end
         if (cmd.tbl_wr_entry) begin
            pool_fill_ff <= pool_fill_in;
         end
         if (cmd.probe_init) begin
            idx_ff <= rem_ff[TAW-1:0];
         end else if (cmd.probe_next || cmd.tbl_clr) begin
            idx_ff <= idx_in;
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_command;
         key_ff  <= req_block_number;
         off_ff  <= req_offset;
         last_ff <= req_last_of_run;
      end
      if (cmd.add) begin
         st_ff <= (off_ok && run_full) ? ST_RUN_LONG : ST_OK;
      end
      if (cmd.hash1) begin
         m1_ff <= mul1;
      end
      if (cmd.hash2) begin
         m2_ff <= mul2;
      end
      if (cmd.hash3) begin
         rem_ff      <= TABLE_POW2 ? (h3 & 32'(TABLE_ENTRIES - 1)) : h3;
         mod_left_ff <= 6'(MOD_STEPS);
      end else if (cmd.mod_step) begin
         // restoring reduction, one shifted divisor per cycle
         if ({32'd0, rem_ff} >= dv) begin
            rem_ff <= rem_ff - dv[31:0];
         end
         mod_left_ff <= mod_left_ff - 6'd1;
      end
      if (cmd.probe_init) begin
         pcnt_ff <= '0;
      end else if (cmd.probe_next) begin
         pcnt_ff <= pcnt_ff + TAW'(1);
      end
      if (cmd.cap_entry) begin
         base_ff <= tbl_q.start;
         len_ff  <= tbl_q.len;
         kind_ff <= tbl_q.bitmap;
      end else if (cmd.sizing) begin
         base_ff <= PAW'(pool_fill_ff);
      end
      if (cmd.sizing) begin
         as_arr_ff <= as_arr_c;
         bytes_ff  <= bytes_c;
         fits_ff   <= fits_c;
      end
      if (cmd.i_clr) begin
         i_ff <= 13'd0;
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + 13'd1;
      end
      if (cmd.cap_lo) begin
         lo_ff <= pool_q;
      end
      if (cmd.respond) begin
         rsp_found_ff  <= cmd.found;
         rsp_status_ff <= cmd.status_force ? cmd.status_code : st_ff;
      end
   end

   always_comb begin
      stat.is_lookup   = cmd_ff;
      stat.off_ok      = off_ok;
      stat.add_drop    = off_ok && run_full;
      stat.last        = last_ff;
      stat.mod_done    = mod_left_ff == 6'd0;
      stat.probe_hit   = !tbl_q.valid || (tbl_q.blk == key_ff);
      stat.entry_valid = tbl_q.valid;
      stat.probe_last  = pcnt_ff == TAW'(TABLE_ENTRIES - 1);
      stat.kind_bitmap = kind_ff;
      stat.bm_out      = len_ff <= look;
      stat.bit_set     = pool_q[look[2:0]];
      stat.lo_match    = {pool_q, lo_ff} == {4'd0, off_ff};
      stat.fits        = fits_ff;
      stat.as_array    = as_arr_ff;
      stat.i_eq_n      = i_ff == {1'b0, run_count_ff};
      stat.i_eq_bytes  = i_ff == bytes_ff;
      stat.i_eq_len    = i_ff == {1'b0, len_ff};
      stat.clear_last  = idx_ff == TAW'(TABLE_ENTRIES - 1);
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: hdl/dtss_ctrl.sv
// Controller state machine sequencing adds, run finish and lookups.
module dtss_ctrl import dtss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_DISP  = 5'd2;
   localparam logic [4:0] S_H1    = 5'd3;
   localparam logic [4:0] S_H2    = 5'd4;
   localparam logic [4:0] S_H3    = 5'd5;
   localparam logic [4:0] S_MOD   = 5'd6;
   localparam logic [4:0] S_PRD   = 5'd7;
   localparam logic [4:0] S_PCHK  = 5'd8;
   localparam logic [4:0] S_SIZE  = 5'd9;
   localparam logic [4:0] S_FIT   = 5'd10;
   localparam logic [4:0] S_ARB   = 5'd11;
   localparam logic [4:0] S_ALO   = 5'd12;
   localparam logic [4:0] S_AHI   = 5'd13;
   localparam logic [4:0] S_ZERO  = 5'd14;
   localparam logic [4:0] S_BRB   = 5'd15;
   localparam logic [4:0] S_BPR   = 5'd16;
   localparam logic [4:0] S_BWR   = 5'd17;
   localparam logic [4:0] S_TWR   = 5'd18;
   localparam logic [4:0] S_LDISP = 5'd19;
   localparam logic [4:0] S_LALO  = 5'd20;
   localparam logic [4:0] S_LAHI  = 5'd21;
   localparam logic [4:0] S_LACMP = 5'd22;
   localparam logic [4:0] S_LBCHK = 5'd23;

   logic [4:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLR: begin
            cmd.tbl_clr = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.is_lookup) begin
               if (!stat.off_ok) begin
                  cmd.respond      = 1'b1;
                  cmd.status_force = 1'b1;
                  cmd.status_code  = ST_OK;
                  state_in         = S_IDLE;
               end else begin
                  state_in = S_H1;
               end
            end else begin
               cmd.add = 1'b1;
               if (stat.last) begin
                  state_in = S_H1;
               end else begin
                  cmd.respond      = 1'b1;
                  cmd.status_force = 1'b1;
                  cmd.status_code  = stat.add_drop ? ST_RUN_LONG : ST_OK;
                  state_in         = S_IDLE;
               end
            end
         end
         S_H1: begin
            cmd.hash1 = 1'b1;
            state_in  = S_H2;
         end
         S_H2: begin
            cmd.hash2 = 1'b1;
            state_in  = S_H3;
         end
         S_H3: begin
            cmd.hash3 = 1'b1;
            state_in  = S_MOD;
         end
         S_MOD: begin
            if (stat.mod_done) begin
               cmd.probe_init = 1'b1;
               state_in       = S_PRD;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         S_PRD: begin
            cmd.tbl_rd = 1'b1;
            state_in   = S_PCHK;
         end
         S_PCHK: begin
            if (stat.probe_hit) begin
               if (!stat.is_lookup) begin
                  state_in = S_SIZE;
               end else if (!stat.entry_valid) begin
                  cmd.respond      = 1'b1;
                  cmd.status_force = 1'b1;
                  cmd.status_code  = ST_OK;
                  state_in         = S_IDLE;
               end else begin
                  cmd.cap_entry = 1'b1;
                  cmd.i_clr     = 1'b1;
                  state_in      = S_LDISP;
               end
            end else if (stat.probe_last) begin
               cmd.respond      = 1'b1;
               cmd.status_force = 1'b1;
               if (stat.is_lookup) begin
                  cmd.status_code = ST_OK;
               end else begin
                  cmd.status_code = ST_TABLE_FULL;
                  cmd.run_reset   = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_PRD;
            end
         end
         S_SIZE: begin
            cmd.sizing = 1'b1;
            state_in   = S_FIT;
         end
         S_FIT: begin
            cmd.i_clr = 1'b1;
            if (!stat.fits) begin
               cmd.respond      = 1'b1;
               cmd.status_force = 1'b1;
               cmd.status_code  = ST_POOL_FULL;
               cmd.run_reset    = 1'b1;
               state_in         = S_IDLE;
            end else if (stat.as_array) begin
               state_in = S_ARB;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ARB: begin
            if (stat.i_eq_n) begin
               state_in = S_TWR;
            end else begin
               cmd.rb_rd = 1'b1;
               state_in  = S_ALO;
            end
         end
         S_ALO: begin
            cmd.pool_op = P_WR_LO;
            state_in    = S_AHI;
         end
         S_AHI: begin
            cmd.pool_op = P_WR_HI;
            cmd.i_inc   = 1'b1;
            state_in    = S_ARB;
         end
         S_ZERO: begin
            // fresh bitmap bytes are cleared before bits are set
            if (stat.i_eq_bytes) begin
               cmd.i_clr = 1'b1;
               state_in  = S_BRB;
            end else begin
               cmd.pool_op = P_WR_ZERO;
               cmd.i_inc   = 1'b1;
            end
         end
         S_BRB: begin
            if (stat.i_eq_n) begin
               state_in = S_TWR;
            end else begin
               cmd.rb_rd = 1'b1;
               state_in  = S_BPR;
            end
         end
         S_BPR: begin
            cmd.pool_op = P_RD_BIT;
            state_in    = S_BWR;
         end
         S_BWR: begin
            cmd.pool_op = P_WR_BIT;
            cmd.i_inc   = 1'b1;
            state_in    = S_BRB;
         end
         S_TWR: begin
            cmd.tbl_wr_entry = 1'b1;
            cmd.run_reset    = 1'b1;
            cmd.respond      = 1'b1;
            state_in         = S_IDLE;
         end
         S_LDISP: begin
            if (!stat.kind_bitmap) begin
               state_in = S_LALO;
            end else if (stat.bm_out) begin
               cmd.respond      = 1'b1;
               cmd.status_force = 1'b1;
               cmd.status_code  = ST_OK;
               state_in         = S_IDLE;
            end else begin
               cmd.pool_op = P_RD_LOOK;
               state_in    = S_LBCHK;
            end
         end
         S_LALO: begin
            if (stat.i_eq_len) begin
               cmd.respond      = 1'b1;
               cmd.status_force = 1'b1;
               cmd.status_code  = ST_OK;
               state_in         = S_IDLE;
            end else begin
               cmd.pool_op = P_RD_LO;
               state_in    = S_LAHI;
            end
         end
         S_LAHI: begin
            cmd.cap_lo  = 1'b1;
            cmd.pool_op = P_RD_HI;
            state_in    = S_LACMP;
         end
         S_LACMP: begin
            if (stat.lo_match) begin
               cmd.respond      = 1'b1;
               cmd.found        = 1'b1;
               cmd.status_force = 1'b1;
               cmd.status_code  = ST_OK;
               state_in         = S_IDLE;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_LALO;
            end
         end
         S_LBCHK: begin
            cmd.respond      = 1'b1;
            cmd.found        = stat.bit_set;
            cmd.status_force = 1'b1;
            cmd.status_code  = ST_OK;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/dead_tuple_set_store.sv
// Dead tuple set store: per-block offset sets in a byte pool with a hashed block table.
// After reset the block table is swept clear, one slot after another, with busy high.
// A transaction is taken when start is high and busy is low, and every transaction gives
// exactly one result, shown for one cycle with rsp_valid; the receiver cannot stall it.
// An add that does not end a run is answered at dispatch. Finishing a run takes dispatch
// and the hash states (plus one reduction step per cycle for a table size that is not a
// power of two), a table read and check per probed slot, then per offset a run buffer read
// and a low and high byte write for an array container, or, after a clearing write per
// bitmap byte, a bit read-modify-write for a bitmap, all limited by the single pool port.
// A lookup does the same hash and probe, then scans array elements or tests a bitmap bit.
module dead_tuple_set_store import dtss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [31:0] req_block_number,
   input  logic [11:0] req_offset,
   input  logic        req_last_of_run,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [1:0]  rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   dtss_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   dtss_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_block_number (req_block_number),
      .req_offset       (req_offset),
      .req_last_of_run  (req_last_of_run),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status)
   );

   // a result only appears once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("found result with nonzero status");

endmodule
